/* hdl/tfb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfb_pkg
// Types, constants and saturation helpers shared by the tilt balance filter.
// ----------------------------------------------------------------------------
package tfb_pkg;

    localparam int DRIVE_LIMIT     = 4800;
    localparam int DRIVE_FIELD_MAX = 8191;
    localparam int DRIVE_LIM_EFF   = (DRIVE_LIMIT < DRIVE_FIELD_MAX) ?
                                     DRIVE_LIMIT : DRIVE_FIELD_MAX;

    localparam int OPND_W    = 39;
    localparam int GAIN_W    = 24;
    localparam int DIG_W     = 8;
    localparam int DIGITS    = GAIN_W / DIG_W;
    localparam int CNT_W     = $clog2(DIGITS);
    localparam int HI_W      = OPND_W + 1;
    localparam int PROD_W    = HI_W + GAIN_W;
    localparam int PP_W      = OPND_W + DIG_W + 1;
    localparam int INTG_W    = 48;
    localparam int RATE_W    = 41;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILT_OFFSET = 4'd0,
        REG_TILT_GAIN   = 4'd1,
        REG_RATE_OFFSET = 4'd2,
        REG_RATE_GAIN   = 4'd3,
        REG_CORR_GAIN   = 4'd4,
        REG_STEP_GAIN   = 4'd5,
        REG_P_GAIN      = 4'd6,
        REG_D_GAIN      = 4'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GAIN,
        ST_MUL_CORR,
        ST_MUL_STEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic signed [15:0] tilt_sample;
        logic signed [15:0] rate_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [13:0] drive;
        logic signed [15:0] filtered_angle;
        logic signed [15:0] scaled_rate;
        logic               drive_clamped;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    function automatic logic signed [OPND_W-1:0] sat39(input logic signed [63:0] x);
        if (x[63:OPND_W-1] == {(64-OPND_W+1){x[63]}}) begin
            return x[OPND_W-1:0];
        end else if (x[63]) begin
            return {1'b1, {(OPND_W-1){1'b0}}};
        end else begin
            return {1'b0, {(OPND_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [INTG_W-1:0] sat48(input logic signed [63:0] x);
        if (x[63:INTG_W-1] == {(64-INTG_W+1){x[63]}}) begin
            return x[INTG_W-1:0];
        end else if (x[63]) begin
            return {1'b1, {(INTG_W-1){1'b0}}};
        end else begin
            return {1'b0, {(INTG_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
        if (x[63:15] == {49{x[63]}}) begin
            return x[15:0];
        end else if (x[63]) begin
            return 16'sh8000;
        end else begin
            return 16'sh7fff;
        end
    endfunction

endpackage

/* hdl/tfb_digit_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfb_digit_mul
// Digit-serial signed multiplier: 39-bit operand times 24-bit gain, one
// 8-bit gain digit per cycle, LSB first, low product bits shifted out.
// ----------------------------------------------------------------------------
module tfb_digit_mul (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [tfb_pkg::OPND_W-1:0]   a,
    input  logic signed [tfb_pkg::GAIN_W-1:0]   b,
    output tfb_pkg::mul_stat_t                  stat,
    output logic signed [tfb_pkg::PROD_W-1:0]   prod
);
    import tfb_pkg::*;

    logic signed [OPND_W-1:0] a_reg;
    logic        [GAIN_W-1:0] b_reg, b_next;
    logic signed [HI_W-1:0]   hi_reg, hi_next;
    logic        [GAIN_W-1:0] lo_reg, lo_next;
    logic        [CNT_W-1:0]  cnt_reg;
    logic                     busy_reg, done_reg;
    logic                     last;
    logic signed [DIG_W:0]    dig;
    logic signed [PP_W-1:0]   pp;
    logic signed [PP_W-1:0]   acc;

    assign last = (cnt_reg == CNT_W'(DIGITS - 1));

    always_comb begin
        // top digit carries the sign of the gain
        if (last) begin
            dig = {b_reg[DIG_W-1], b_reg[DIG_W-1:0]};
        end else begin
            dig = {1'b0, b_reg[DIG_W-1:0]};
        end
        pp      = a_reg * dig;
        acc     = {{(PP_W-HI_W){hi_reg[HI_W-1]}}, hi_reg} + pp;
        hi_next = acc[PP_W-1:DIG_W];
        lo_next = {acc[DIG_W-1:0], lo_reg[GAIN_W-1:DIG_W]};
        b_next  = {{DIG_W{1'b0}}, b_reg[GAIN_W-1:DIG_W]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            b_reg  <= b;
            hi_reg <= '0;
            lo_reg <= '0;
        end else if (busy_reg) begin
            b_reg  <= b_next;
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = {hi_reg, lo_reg};

endmodule

/* hdl/tilt_filter_balance_pd.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_filter_balance_pd
// Complementary tilt filter with PD balance law, digit-serial arithmetic.
// ----------------------------------------------------------------------------
// s_ (valid/ready) takes one beat per control period: tilt and rate sample.
// m_ (valid/ready) returns one beat per input: drive, filtered angle,
// scaled rate and clamp flag.
// cfg_ (valid/ready) writes gain/offset registers by index 0..7; other
// indexes are dropped. cfg_ready is always high.
// A new input is taken only in the idle state, after the last result is
// done. Each input takes three passes through a pair of digit-serial
// multipliers, each pass three 8-bit gain digits plus a turnaround.
// A finished result sits in the output register; a new input is taken
// while it waits. If the receiver still stalls when the next result is
// done, the block holds in its last state and takes no input.
// Reset clears the angle integral, loads the register defaults and
// empties the output register.
// ----------------------------------------------------------------------------
module tilt_filter_balance_pd (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  tfb_pkg::in_item_t                     s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output tfb_pkg::out_item_t                    m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tfb_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tfb_pkg::CFG_DAT_W-1:0]         cfg_data
);
    import tfb_pkg::*;

    localparam logic signed [31:0] LIM_POS = 32'(DRIVE_LIM_EFF);
    localparam logic signed [31:0] LIM_NEG = -LIM_POS;

    logic signed [15:0]       tilt_off_reg, rate_off_reg;
    logic signed [GAIN_W-1:0] tilt_gain_reg, rate_gain_reg, corr_gain_reg;
    logic        [22:0]       step_gain_reg;
    logic signed [GAIN_W-1:0] p_gain_reg, d_gain_reg;

    state_t                   state_reg, state_next;
    logic signed [INTG_W-1:0] intg_reg, intg_next;
    logic signed [RATE_W-1:0] rate_reg, rate_next;
    logic signed [15:0]       filt_reg, filt_next;
    logic signed [63:0]       pd_reg, pd_next;
    out_item_t                out_reg, out_next;
    logic                     m_valid_reg, m_valid_next;

    logic                     mul_start;
    logic signed [OPND_W-1:0] a0, a1;
    logic signed [GAIN_W-1:0] b0, b1;
    mul_stat_t                stat0, stat1;
    logic signed [PROD_W-1:0] prod0, prod1;

    logic signed [16:0]       dt, dr;
    logic signed [63:0]       intg_ext, rate_ext, p0_ext, p1_ext, p0_shr;
    logic signed [31:0]       raw;
    logic                     load_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tilt_off_reg  <= 16'sd150;
            tilt_gain_reg <= 24'sd65536;
            rate_off_reg  <= 16'sd0;
            rate_gain_reg <= 24'sd114688;
            corr_gain_reg <= 24'sd32768;
            step_gain_reg <= 23'd655;
            p_gain_reg    <= -24'sd42598;
            d_gain_reg    <= -24'sd1016;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_idx_t'(cfg_index))
                REG_TILT_OFFSET: tilt_off_reg  <= cfg_data[15:0];
                REG_TILT_GAIN:   tilt_gain_reg <= cfg_data;
                REG_RATE_OFFSET: rate_off_reg  <= cfg_data[15:0];
                REG_RATE_GAIN:   rate_gain_reg <= cfg_data;
                REG_CORR_GAIN:   corr_gain_reg <= cfg_data;
                REG_STEP_GAIN:   step_gain_reg <= cfg_data[22:0];
                REG_P_GAIN:      p_gain_reg    <= cfg_data;
                REG_D_GAIN:      d_gain_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    tfb_digit_mul u_mul0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (a0),
        .b       (b0),
        .stat    (stat0),
        .prod    (prod0)
    );

    tfb_digit_mul u_mul1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (a1),
        .b       (b1),
        .stat    (stat1),
        .prod    (prod1)
    );

    always_comb begin
        dt       = {s_data.tilt_sample[15], s_data.tilt_sample}
                   - {tilt_off_reg[15], tilt_off_reg};
        dr       = {s_data.rate_sample[15], s_data.rate_sample}
                   - {rate_off_reg[15], rate_off_reg};
        intg_ext = {{(64-INTG_W){intg_reg[INTG_W-1]}}, intg_reg};
        rate_ext = {{(64-RATE_W){rate_reg[RATE_W-1]}}, rate_reg};
        p0_ext   = prod0;
        p1_ext   = prod1;
        p0_shr   = p0_ext >>> 16;
        raw      = pd_reg[63:32];

        out_next.filtered_angle = filt_reg;
        out_next.scaled_rate    = sat16(rate_ext >>> 16);
        if (raw > LIM_POS) begin
            out_next.drive         = LIM_POS[13:0];
            out_next.drive_clamped = 1'b1;
        end else if (raw < LIM_NEG) begin
            out_next.drive         = LIM_NEG[13:0];
            out_next.drive_clamped = 1'b1;
        end else begin
            out_next.drive         = raw[13:0];
            out_next.drive_clamped = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        intg_next  = intg_reg;
        rate_next  = rate_reg;
        filt_next  = filt_reg;
        pd_next    = pd_reg;
        mul_start  = 1'b0;
        a0         = '0;
        a1         = '0;
        b0         = '0;
        b1         = '0;
        s_ready    = 1'b0;
        load_out   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                a0      = {{(OPND_W-17){dt[16]}}, dt};
                b0      = tilt_gain_reg;
                a1      = {{(OPND_W-17){dr[16]}}, dr};
                b1      = rate_gain_reg;
                if (s_valid) begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL_GAIN;
                end
            end
            ST_MUL_GAIN: begin
                a0 = sat39(p0_ext - intg_ext);
                b0 = corr_gain_reg;
                a1 = sat39(intg_ext);
                b1 = p_gain_reg;
                if (stat0.done) begin
                    rate_next  = prod1[RATE_W-1:0];
                    filt_next  = sat16(intg_ext >>> 16);
                    mul_start  = 1'b1;
                    state_next = ST_MUL_CORR;
                end
            end
            ST_MUL_CORR: begin
                a0 = sat39(rate_ext + p0_shr);
                b0 = {1'b0, step_gain_reg};
                a1 = sat39(rate_ext);
                b1 = d_gain_reg;
                if (stat0.done) begin
                    pd_next    = p1_ext;
                    mul_start  = 1'b1;
                    state_next = ST_MUL_STEP;
                end
            end
            ST_MUL_STEP: begin
                if (stat0.done) begin
                    intg_next  = sat48(intg_ext + p0_shr);
                    pd_next    = -pd_reg - p1_ext;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            intg_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            intg_reg    <= intg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rate_reg <= rate_next;
        filt_reg <= filt_next;
        pd_reg   <= pd_next;
        if (load_out) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // both multipliers are always launched together
    a_mul_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat0.done == stat1.done) && (stat0.busy == stat1.busy))
        else $error("multiplier pair out of step");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (stat0.busy && state_reg == ST_MUL_GAIN))
        else $error("accepted beat did not start the multipliers");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !stat0.busy)
        else $error("input ready while multiplier busy");

    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_data.drive) <= LIM_POS && 32'(m_data.drive) >= LIM_NEG))
        else $error("drive outside limit");

    a_clamp_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.drive_clamped) |->
            (32'(m_data.drive) == LIM_POS || 32'(m_data.drive) == LIM_NEG))
        else $error("clamp flag without drive at limit");

endmodule
